// ===== src/mctt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mctt_pkg
// Shared types and constants of the multi-channel periodic tick timer.
// ----------------------------------------------------------------------------
package mctt_pkg;

    localparam int CHANNELS_DEF    = 10;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int PERIOD_W = 16;   // width of the period field on the input
    localparam int CHAN_W   = 4;    // width of the slot index on the output

    localparam logic KIND_REG  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [PERIOD_W-1:0] period_ticks;
        logic                tick_driven;
        logic                has_handler;
    } t_in;

    typedef struct packed {
        logic [CHAN_W-1:0] fired_channel;
        logic              last;
    } t_out;

    // strobes from the walker to the slot store
    typedef struct packed {
        logic reg_en;   // register item transfer: claim next free slot
        logic rd_en;    // read slot at rd_addr
        logic wr_en;    // write back countdown at wr_addr
    } t_store_ctl;

endpackage : mctt_pkg
`default_nettype wire

// ===== src/mctt_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mctt_store
// Slot table: period/countdown memory, active flags and claimed-slot count.
// ----------------------------------------------------------------------------
module mctt_store #(
    parameter int CHANNELS    = mctt_pkg::CHANNELS_DEF,
    parameter int COUNT_WIDTH = mctt_pkg::COUNT_WIDTH_DEF,
    localparam int IW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int CNTW = $clog2(CHANNELS + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire mctt_pkg::t_store_ctl   i_ctl,
    input  wire logic [COUNT_WIDTH-1:0] i_reg_period,
    input  wire logic                   i_reg_active,
    input  wire logic [IW-1:0]          i_rd_addr,
    input  wire logic [IW-1:0]          i_wr_addr,
    input  wire logic [COUNT_WIDTH-1:0] i_wr_cd,
    output logic      [CNTW-1:0]        o_count,
    output logic      [COUNT_WIDTH-1:0] o_rd_period,
    output logic      [COUNT_WIDTH-1:0] o_rd_cd,
    output logic                        o_rd_active
);

    // entry = {period, countdown}
    logic [2*COUNT_WIDTH-1:0] r_mem [CHANNELS];
    logic [2*COUNT_WIDTH-1:0] r_rdata;
    logic [CHANNELS-1:0]      r_active;
    logic                     r_rd_active;
    logic [CNTW-1:0]          r_count;

    logic                     claim;
    logic                     mem_we;
    logic [IW-1:0]            mem_wa;
    logic [2*COUNT_WIDTH-1:0] mem_wd;

    assign claim = i_ctl.reg_en && (r_count < CNTW'(CHANNELS));

    // register and tick write-backs never fall in the same cycle
    always_comb begin
        if (claim) begin
            mem_we = 1'b1;
            mem_wa = r_count[IW-1:0];
            mem_wd = {i_reg_period, i_reg_period};
        end else begin
            mem_we = i_ctl.wr_en;
            mem_wa = i_wr_addr;
            mem_wd = {r_rdata[2*COUNT_WIDTH-1:COUNT_WIDTH], i_wr_cd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_ctl.rd_en) begin
            r_rdata     <= r_mem[i_rd_addr];
            r_rd_active <= r_active[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_active <= '0;
        end else if (claim) begin
            r_count                     <= r_count + CNTW'(1);
            r_active[r_count[IW-1:0]]   <= i_reg_active;
        end
    end

    assign o_count     = r_count;
    assign o_rd_period = r_rdata[2*COUNT_WIDTH-1:COUNT_WIDTH];
    assign o_rd_cd     = r_rdata[COUNT_WIDTH-1:0];
    assign o_rd_active = r_rd_active;

endmodule : mctt_store
`default_nettype wire

// ===== src/multi_channel_periodic_tick_timer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Register item: taken in idle; no result.
// Tick item: walks the claimed slots (none for an empty table), one slot per
// cycle through the slot memory read/modify/write loop while the output does not stall.
// Each expiry is held back until the next one is found (or the walk ends), then registered onto the output.
// Reset (synchronous, active low) clears slot count, active flags and control;
// the slot memory itself is not cleared.
// ----------------------------------------------------------------------------
// multi_channel_periodic_tick_timer
// Table of periodic countdown timers; each tick walks the claimed slots and
// reports every slot that expires, flagging the last one of the tick.
// ----------------------------------------------------------------------------
module multi_channel_periodic_tick_timer #(
    parameter int CHANNELS    = mctt_pkg::CHANNELS_DEF,
    parameter int COUNT_WIDTH = mctt_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire mctt_pkg::t_in i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output mctt_pkg::t_out     o_out
);

    localparam int IW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNTW = $clog2(CHANNELS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [IW-1:0]          r_idx, n_idx;
    logic                   r_pend, n_pend;        // an expiry held back
    logic [IW-1:0]          r_pend_idx, n_pend_idx;
    logic                   r_out_valid;
    mctt_pkg::t_out         r_out;

    mctt_pkg::t_store_ctl   ctl;
    logic [IW-1:0]          rd_addr;
    logic [COUNT_WIDTH-1:0] wr_cd;
    logic [CNTW-1:0]        count;
    logic [COUNT_WIDTH-1:0] rd_period, rd_cd, dec;
    logic                   rd_active;

    logic in_xfer, tick_xfer, out_free, fire, stall, last_slot;
    logic out_load, out_last;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign tick_xfer  = in_xfer && (i_in.kind == mctt_pkg::KIND_TICK);
    assign out_free   = !r_out_valid || i_out_ready;

    // slot under inspection in WALK: read data belongs to r_idx
    assign dec       = rd_cd - COUNT_WIDTH'(1);
    assign fire      = rd_active && (dec == '0);
    // a second expiry must push the held one out; wait for the output slot
    assign stall     = fire && r_pend && !out_free;
    assign last_slot = ((CNTW'(r_idx) + CNTW'(1)) == count);

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        ctl.reg_en = in_xfer && (i_in.kind == mctt_pkg::KIND_REG);
        ctl.rd_en  = 1'b0;
        ctl.wr_en  = 1'b0;
        rd_addr    = '0;
        wr_cd      = fire ? rd_period : dec;
        out_load   = 1'b0;
        out_last   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (tick_xfer && (count != '0)) begin
                    ctl.rd_en = 1'b1;
                    n_idx     = '0;
                    n_state   = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!stall) begin
                    ctl.wr_en = rd_active;
                    if (fire) begin
                        n_pend     = 1'b1;
                        n_pend_idx = r_idx;
                        out_load   = r_pend;
                    end
                    if (last_slot) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_idx     = r_idx + IW'(1);
                        ctl.rd_en = 1'b1;
                        rd_addr   = r_idx + IW'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    out_load = 1'b1;
                    out_last = 1'b1;
                    n_pend   = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        if (out_load) begin
            r_out.fired_channel <= mctt_pkg::CHAN_W'(r_pend_idx);
            r_out.last          <= out_last;
        end
    end

    mctt_store #(
        .CHANNELS    (CHANNELS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_reg_period (COUNT_WIDTH'(i_in.period_ticks)),
        .i_reg_active (i_in.tick_driven && i_in.has_handler),
        .i_rd_addr    (rd_addr),
        .i_wr_addr    (r_idx),
        .i_wr_cd      (wr_cd),
        .o_count      (count),
        .o_rd_period  (rd_period),
        .o_rd_cd      (rd_cd),
        .o_rd_active  (rd_active)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // nothing is held back once the walk is over
    a_no_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend)
        else $error("expiry left pending in idle");

    // walk index stays inside the claimed slots
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (CNTW'(r_idx) < count))
        else $error("walk index beyond claimed slots");

    // slot count never exceeds the table
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CNTW'(CHANNELS))
        else $error("slot count above table size");

    // a tick on an empty table leaves the block idle
    a_empty_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_xfer && (count == '0)) |=> (r_state == ST_IDLE))
        else $error("empty-table tick started a walk");

endmodule : multi_channel_periodic_tick_timer
`default_nettype wire

// ===== dv/tb_multi_channel_periodic_tick_timer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_channel_periodic_tick_timer
// Drives register and tick transfers into the timer table, holds its own copy
// of the slot table to predict every expiry, and checks each result transfer
// in order against that prediction, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_multi_channel_periodic_tick_timer;

    localparam int NUM_SLOTS   = mctt_pkg::CHANNELS_DEF;
    localparam int CNT_W       = mctt_pkg::COUNT_WIDTH_DEF;
    localparam int ITEM_TARGET = 400;
    // cycles with no transfer on either channel before the run is abandoned
    localparam int STALL_LIMIT = 2000;

    // ------------------------------------------------------------------------
    // Expiry predictor: a private copy of the slot table. Each input transfer
    // is applied to it; every expiry a tick causes is queued in slot order.
    // ------------------------------------------------------------------------
    class tick_table_sb;
        logic [CNT_W-1:0] reload_q [NUM_SLOTS];
        logic [CNT_W-1:0] count_q [NUM_SLOTS];
        bit               armed [NUM_SLOTS];
        int               claimed;
        int               items_taken;
        int               errors;
        mctt_pkg::t_out   expiries [$];

        function void note_input(mctt_pkg::t_in item);
            mctt_pkg::t_out fresh [$];
            mctt_pkg::t_out rec;
            items_taken++;
            if (item.kind == mctt_pkg::KIND_REG) begin
                // a full table drops the request silently
                if (claimed < NUM_SLOTS) begin
                    reload_q[claimed] = item.period_ticks[CNT_W-1:0];
                    count_q[claimed]  = item.period_ticks[CNT_W-1:0];
                    armed[claimed]    = item.tick_driven && item.has_handler;
                    claimed++;
                end
                return;
            end
            for (int i = 0; i < claimed; i++) begin
                if (armed[i]) begin
                    // period zero wraps here to all ones
                    count_q[i] = count_q[i] - 1'b1;
                    if (count_q[i] == '0) begin
                        rec.fired_channel = mctt_pkg::CHAN_W'(i);
                        rec.last          = 1'b0;
                        fresh.push_back(rec);
                        count_q[i] = reload_q[i];
                    end
                end
            end
            if (fresh.size() > 0)
                fresh[fresh.size()-1].last = 1'b1;
            foreach (fresh[k])
                expiries.push_back(fresh[k]);
        endfunction

        function void check_result(mctt_pkg::t_out got);
            mctt_pkg::t_out want;
            if (expiries.size() == 0) begin
                $display("%0t: unexpected expiry, expected none, got slot %0d last %0b",
                         $time, got.fired_channel, got.last);
                errors++;
                return;
            end
            want = expiries.pop_front();
            if (got.fired_channel !== want.fired_channel) begin
                $display("%0t: fired_channel mismatch, expected %0d, got %0d",
                         $time, want.fired_channel, got.fired_channel);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last mismatch (slot %0d), expected %0b, got %0b",
                         $time, want.fired_channel, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           out_ready = 1'b0;
    mctt_pkg::t_in  in_item   = '0;
    logic           in_ready;
    logic           out_valid;
    mctt_pkg::t_out out_item;

    tick_table_sb sb = new;
    int in_quiet  = 0;
    int out_quiet = 0;
    int idle_cycles = 0;

    multi_channel_periodic_tick_timer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Gap before a transfer: mostly drawn at random, with occasional runs of
    // back-to-back transfers so that stretches without idling occur too.
    function automatic int draw_gap(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet_left = $urandom_range(8, 32);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic mctt_pkg::t_in make_reg(logic [mctt_pkg::PERIOD_W-1:0] period,
                                               logic td, logic hh);
        mctt_pkg::t_in item;
        item.kind         = mctt_pkg::KIND_REG;
        item.period_ticks = period;
        item.tick_driven  = td;
        item.has_handler  = hh;
        return item;
    endfunction

    // unused fields of a tick carry random junk
    function automatic mctt_pkg::t_in make_tick();
        mctt_pkg::t_in item;
        item.kind         = mctt_pkg::KIND_TICK;
        item.period_ticks = mctt_pkg::PERIOD_W'($urandom);
        item.tick_driven  = 1'($urandom);
        item.has_handler  = 1'($urandom);
        return item;
    endfunction

    // Called at a rising edge. Valid is only lowered when a gap is drawn, so a
    // back-to-back transfer keeps it high without a second assignment.
    task automatic drive_item(mctt_pkg::t_in item);
        int gap;
        gap = draw_gap(in_quiet);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(item);
    endtask

    // Random register request: mostly short periods so expiries are frequent,
    // some mid-range and some anywhere in the field.
    function automatic mctt_pkg::t_in random_reg();
        int sel;
        logic [mctt_pkg::PERIOD_W-1:0] period;
        sel = $urandom_range(0, 19);
        if (sel < 14)
            period = mctt_pkg::PERIOD_W'($urandom_range(1, 12));
        else if (sel < 17)
            period = mctt_pkg::PERIOD_W'($urandom_range(13, 40));
        else
            period = mctt_pkg::PERIOD_W'($urandom);
        if ($urandom_range(0, 4) != 0)
            return make_reg(period, 1'b1, 1'b1);
        return make_reg(period, 1'($urandom), 1'($urandom));
    endfunction

    // Result side: stall ready for a drawn number of cycles after each
    // transfer, then hold it high until the next result is taken.
    initial begin
        int gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            gap = draw_gap(out_quiet);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready)) @(posedge clk);
        end
    end

    // Every result transfer is checked at the edge that completes it.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_item);
    end

    // Watchdog: counts edges with no transfer on either channel.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_multi_channel_periodic_tick_timer: done, errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part ---
        drive_item(make_tick());                        // tick on an empty table
        drive_item(make_reg(16'd1, 1'b1, 1'b1));        // slot 0: fires on every tick
        drive_item(make_tick());
        drive_item(make_reg(16'd0, 1'b1, 1'b1));        // slot 1: zero period, wraps
        drive_item(make_reg(16'hFFFF, 1'b1, 1'b1));     // slot 2: longest period
        drive_item(make_reg(16'd3, 1'b0, 1'b1));        // slot 3: not tick driven
        drive_item(make_reg(16'd2, 1'b1, 1'b0));        // slot 4: no handler
        drive_item(make_reg(16'd2, 1'b1, 1'b1));        // slot 5
        drive_item(make_reg(16'd3, 1'b1, 1'b1));        // slot 6
        repeat (8) drive_item(make_tick());             // several expiries per tick

        // --- random part: mostly ticks; requests fill the remaining slots and,
        // once the table is full, a few more check that they are dropped ---
        while (sb.items_taken < ITEM_TARGET) begin
            if (sb.claimed < NUM_SLOTS && $urandom_range(0, 3) == 0)
                drive_item(random_reg());
            else if (sb.claimed >= NUM_SLOTS && $urandom_range(0, 19) == 0)
                drive_item(random_reg());
            else
                drive_item(make_tick());
        end
        in_valid <= 1'b0;

        // drain outstanding expiries, then watch for strays
        while (sb.expiries.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);

        if (sb.errors == 0)
            $display("tb_multi_channel_periodic_tick_timer: done, clean");
        else
            $display("tb_multi_channel_periodic_tick_timer: done, errors");
        $finish;
    end

endmodule
